// ===== sv/dcm_pkg.sv =====
// Shared types and constants for the DSP command mailbox.
`timescale 1ns / 1ps

package dcm_pkg;

  // Bus access codes
  typedef logic [2:0] func_t;
  localparam func_t FN_READ_STAT  = 3'd0;
  localparam func_t FN_READ_DATA  = 3'd1;
  localparam func_t FN_WRITE_WAKE = 3'd2;
  localparam func_t FN_WRITE_LOW  = 3'd3;
  localparam func_t FN_WRITE_CMD  = 3'd4;

  // Canned replies and command values
  localparam logic [7:0]  REPLY_D0      = 8'h5a;
  localparam logic [7:0]  REPLY_70      = 8'h06;
  localparam logic [7:0]  REPLY_EMPTY   = 8'hff;
  localparam logic [15:0] CMD_TRANS_ON  = 16'h7004;
  localparam logic [15:0] CMD_SLEEP     = 16'h8000;
  localparam logic [15:0] CMD_TRANS_OFF = 16'hffff;
  localparam logic [7:0]  HIGH_D0       = 8'hd0;
  localparam logic [7:0]  HIGH_70       = 8'h70;
  localparam logic [7:0]  HIGH_LIMIT    = 8'h60;
  localparam logic [7:0]  HIGH_FWD      = 8'ha0;
  localparam logic [7:0]  LOW_70_A      = 8'h01;
  localparam logic [7:0]  LOW_70_B      = 8'h02;
  localparam logic [2:0]  MODE_ALL      = 3'd4;
  localparam logic [2:0]  MODE_LOW_A    = 3'd1;
  localparam logic [2:0]  MODE_LOW_B    = 3'd2;

  typedef struct packed {
    func_t      func;
    logic [7:0] data_value;
    logic       dsp_busy;
    logic [2:0] dsp_mode;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       forward_valid;
    logic [7:0] forward_high;
    logic [7:0] forward_low;
    logic       dsp_reset_pulse;
  } rsp_t;

endpackage

// ===== sv/dcm_if.sv =====
// Valid/ready channel interfaces for mailbox requests and results.
`timescale 1ns / 1ps

interface dcm_req_if;
  logic         valid;
  logic         ready;
  dcm_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dcm_rsp_if;
  logic         valid;
  logic         ready;
  dcm_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/dsp_command_mailbox.sv =====
// Top level of the host-side DSP command mailbox.
`timescale 1ns / 1ps

// Host-side mailbox in front of a sound DSP. Every bus access on req (status
// read, return-data read, wake/reset write, data-low write, command write)
// produces exactly one result on rsp, in the cycle after the access is taken.
// All flag updates and the result are computed combinationally from the
// access and the current flags, so the block takes one access per cycle;
// the output register frees itself whenever rsp is taken, and req stalls
// only while a result is waiting and rsp.ready is low. No setup is needed
// after reset.
module dsp_command_mailbox (
  input  logic clk,
  input  logic rst,
  dcm_req_if.sink   req,
  dcm_rsp_if.source rsp
);

  // Mailbox state
  logic [7:0] reply_byte;
  logic       reply_valid;
  logic       trans_mode;
  logic       sleep_flag;
  logic       ready_d0;
  logic       ready_70;
  logic       data_pending;
  logic [7:0] low_byte;

  logic [7:0] reply_byte_next;
  logic       reply_valid_next;
  logic       trans_mode_next;
  logic       sleep_flag_next;
  logic       ready_d0_next;
  logic       ready_70_next;
  logic       data_pending_next;
  logic [7:0] low_byte_next;

  dcm_pkg::rsp_t result;
  dcm_pkg::rsp_t out_data;
  logic          out_valid;
  logic          accept;
  logic [15:0]   cmd;
  logic [7:0]    val;

  assign req.ready   = !out_valid || rsp.ready;
  assign accept      = req.valid && req.ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;
  assign val         = req.payload.data_value;
  assign cmd         = {val, low_byte};

  // Compute flag updates and the result for one transaction
  always_comb begin
    reply_byte_next   = reply_byte;
    reply_valid_next  = reply_valid;
    trans_mode_next   = trans_mode;
    sleep_flag_next   = sleep_flag;
    ready_d0_next     = ready_d0;
    ready_70_next     = ready_70;
    data_pending_next = data_pending;
    low_byte_next     = low_byte;
    result            = '0;

    unique case (req.payload.func)
      dcm_pkg::FN_READ_STAT: begin
        result.read_data[7] = sleep_flag;
        if (!sleep_flag && req.payload.dsp_busy) begin
          result.read_data[5:4] = {2{data_pending}};
        end else begin
          data_pending_next = 1'b0;
        end
        result.read_data[6] = ready_d0 || ready_70 || (trans_mode && reply_valid);
      end
      dcm_pkg::FN_READ_DATA: begin
        if (reply_valid) begin
          result.read_data = reply_byte;
          reply_valid_next = 1'b0;
        end else begin
          result.read_data = dcm_pkg::REPLY_EMPTY;
        end
      end
      dcm_pkg::FN_WRITE_WAKE: begin
        if (val[7] || val[6]) begin
          sleep_flag_next        = 1'b0;
          result.dsp_reset_pulse = 1'b1;
        end
        if (val[6]) begin
          reply_valid_next  = 1'b0;
          data_pending_next = 1'b0;
          trans_mode_next   = 1'b0;
          ready_70_next     = 1'b0;
          ready_d0_next     = 1'b0;
        end
      end
      dcm_pkg::FN_WRITE_LOW: begin
        low_byte_next = val;
      end
      dcm_pkg::FN_WRITE_CMD: begin
        // Flag updates driven by the command word
        if (cmd == dcm_pkg::CMD_TRANS_OFF) trans_mode_next = 1'b0;
        if (cmd == dcm_pkg::CMD_SLEEP) sleep_flag_next = 1'b1;
        if (!trans_mode_next) begin
          if (val == dcm_pkg::HIGH_D0) begin
            reply_byte_next  = dcm_pkg::REPLY_D0;
            reply_valid_next = 1'b1;
            ready_d0_next    = 1'b1;
          end else if (val > dcm_pkg::HIGH_LIMIT) begin
            ready_d0_next = 1'b0;
          end
          if (val == dcm_pkg::HIGH_70) begin
            if (low_byte == dcm_pkg::LOW_70_A || low_byte == dcm_pkg::LOW_70_B) begin
              ready_70_next    = 1'b1;
              reply_byte_next  = dcm_pkg::REPLY_70;
              reply_valid_next = 1'b1;
            end else begin
              ready_70_next = 1'b0;
            end
          end else if (val >= dcm_pkg::HIGH_LIMIT) begin
            ready_70_next = 1'b0;
          end
          if (cmd == dcm_pkg::CMD_TRANS_ON) trans_mode_next = 1'b1;
        end
        // Echo in pass-through mode, else mark pending (DSP awake and busy) and forward qualifying commands
        if (trans_mode_next) begin
          reply_byte_next  = low_byte;
          reply_valid_next = 1'b1;
        end else begin
          if (!sleep_flag_next && req.payload.dsp_busy) data_pending_next = 1'b1;
          if (val == dcm_pkg::HIGH_FWD || val[7] || val[6] ||
              req.payload.dsp_mode == dcm_pkg::MODE_ALL ||
              ((req.payload.dsp_mode == dcm_pkg::MODE_LOW_A ||
                req.payload.dsp_mode == dcm_pkg::MODE_LOW_B) &&
               val < dcm_pkg::HIGH_LIMIT)) begin
            result.forward_valid = 1'b1;
            result.forward_high  = val;
            result.forward_low   = low_byte;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Update state on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_byte   <= '0;
      reply_valid  <= 1'b0;
      trans_mode   <= 1'b0;
      sleep_flag   <= 1'b0;
      ready_d0     <= 1'b0;
      ready_70     <= 1'b0;
      data_pending <= 1'b0;
      low_byte     <= '0;
    end else if (accept) begin
      reply_byte   <= reply_byte_next;
      reply_valid  <= reply_valid_next;
      trans_mode   <= trans_mode_next;
      sleep_flag   <= sleep_flag_next;
      ready_d0     <= ready_d0_next;
      ready_70     <= ready_70_next;
      data_pending <= data_pending_next;
      low_byte     <= low_byte_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // Every accepted transaction shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("result missing after accepted transaction");

  // A full wake/reset clears pass-through and the reply
  a_wake_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && req.payload.func == dcm_pkg::FN_WRITE_WAKE && req.payload.data_value[6])
    |=> (!trans_mode && !reply_valid && !ready_d0 && !ready_70 && !data_pending))
    else $error("wake/reset did not clear mailbox flags");

  // Forwarded bytes are zero unless a command is forwarded
  a_fwd_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.payload.forward_valid) |->
    (rsp.payload.forward_high == 8'h00 && rsp.payload.forward_low == 8'h00))
    else $error("forward bytes set without forward_valid");

  // A result never both forwards and resets the DSP
  a_fwd_rst: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.payload.forward_valid && rsp.payload.dsp_reset_pulse))
    else $error("forward and reset in one result");

endmodule
